/* rtl/core/erle_pkg.sv */
// Shared types and constants for the escaped run-length encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package erle_pkg;

    localparam int BYTE_W           = 8;
    localparam int THR_W            = 2;
    localparam int CNT_W            = 24;   // output byte count / capacity width
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 24;
    localparam int MAX_LENGTH_WIDTH = 32;
    localparam int LENGTH_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd3;

    localparam logic [BYTE_W-1:0] ESCAPE_RST    = 8'hFF;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 2'd3;
    localparam logic [BYTE_W-1:0] MAX_RUN_RST   = 8'd255;
    localparam logic [CNT_W-1:0]  CAPACITY_RST  = 24'hFFFFFF;

    // Bytes of an encoded run: escape, value, count
    localparam logic [1:0] ENC_BYTES = 2'd3;

    // One flushed run
    typedef struct packed {
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] len;
        logic              enc;
        logic [1:0]        nbytes;  // bytes it expands to, 0 if none
    } run_t;

    // Work handed from front to back for one item
    typedef struct packed {
        run_t             a;        // run closed by this item
        run_t             b;        // run flushed by the final byte
        logic             fin;
        logic [CNT_W-1:0] total;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/erle_in_if.sv */
// Input channel of the encoder: one raw byte per item plus the final flag.
// Depends on erle_pkg.
`default_nettype none

interface erle_in_if;
    import erle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/erle_out_if.sv */
// Output channel of the encoder: one coded byte or end marker per item.
// Depends on erle_pkg.
`default_nettype none

interface erle_out_if #(
    parameter int LENGTH_WIDTH = erle_pkg::LENGTH_WIDTH_DEF
);
    import erle_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BYTE_W-1:0]       out_byte;
    logic                    byte_valid;
    logic                    end_of_buffer;
    logic [LENGTH_WIDTH-1:0] total_length;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_buffer, output total_length, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_buffer, input total_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/erle_front.sv */
// Front end: tracks the open run, decides flushes and run starts, and
// builds one command per item that produces output. Depends on erle_pkg.
`default_nettype none

module erle_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       acc,
    input  wire logic [erle_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       final_byte,
    input  wire logic [erle_pkg::THR_W-1:0] run_threshold,
    input  wire logic [erle_pkg::BYTE_W-1:0] max_run,
    input  wire logic [erle_pkg::CNT_W-1:0] output_capacity,
    output logic                            push,
    output erle_pkg::cmd_t                  cmd
);
    import erle_pkg::*;

    logic [BYTE_W-1:0] run_val_reg, run_val_next;
    logic [BYTE_W-1:0] run_len_reg, run_len_next;
    logic              full_reg, full_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              cont;
    logic              a_has;
    logic              start_ok;
    logic [CNT_W-1:0]  cnt_a;
    logic [BYTE_W-1:0] new_len;
    logic [BYTE_W-1:0] new_val;
    logic              new_full;
    logic [BYTE_W-1:0] thr_ext;
    run_t              ra;
    run_t              rb;

    assign thr_ext = BYTE_W'(run_threshold);

    always_comb
    begin
        cont = (run_len_reg != '0) && (data_byte == run_val_reg) && (run_len_reg < max_run);
        a_has = !cont && (run_len_reg != '0);

        ra.val    = run_val_reg;
        ra.len    = run_len_reg;
        ra.enc    = run_len_reg > thr_ext;
        ra.nbytes = !a_has ? 2'd0 : (ra.enc ? ENC_BYTES : run_len_reg[1:0]);

        cnt_a = count_reg + CNT_W'(ra.nbytes);
        // room for a whole encoded run must remain
        start_ok = !cont && !full_reg &&
                   ((CNT_W+1)'(cnt_a) + (CNT_W+1)'(2) < (CNT_W+1)'(output_capacity));

        if (cont)
        begin
            new_len = run_len_reg + BYTE_W'(1);
            new_val = run_val_reg;
        end
        else if (start_ok)
        begin
            new_len = BYTE_W'(1);
            new_val = data_byte;
        end
        else
        begin
            new_len = '0;
            new_val = run_val_reg;
        end
        new_full = full_reg || (!cont && !start_ok);

        rb.val    = new_val;
        rb.len    = new_len;
        rb.enc    = new_len > thr_ext;
        rb.nbytes = (!final_byte || new_len == '0) ? 2'd0 :
                    (rb.enc ? ENC_BYTES : new_len[1:0]);

        cmd.a     = ra;
        cmd.b     = rb;
        cmd.fin   = final_byte;
        cmd.total = cnt_a + CNT_W'(rb.nbytes);

        push = acc && (a_has || final_byte);

        run_val_next = run_val_reg;
        run_len_next = run_len_reg;
        full_next    = full_reg;
        count_next   = count_reg;
        if (acc)
        begin
            if (final_byte)
            begin
                run_val_next = '0;
                run_len_next = '0;
                full_next    = 1'b0;
                count_next   = '0;
            end
            else
            begin
                run_val_next = new_val;
                run_len_next = new_len;
                full_next    = new_full;
                count_next   = cnt_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_val_reg <= '0;
            run_len_reg <= '0;
            full_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            run_val_reg <= run_val_next;
            run_len_reg <= run_len_next;
            full_reg    <= full_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/erle_queue.sv */
// Short command queue between front and back ends, register based.
// Depends on erle_pkg for the command type.
`default_nettype none

module erle_queue #(
    parameter int DEPTH = erle_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire erle_pkg::cmd_t wdata,
    output logic                full,
    input  wire logic           pop,
    output logic                nonempty,
    output erle_pkg::cmd_t      rdata
);
    import erle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(DEPTH);

    cmd_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (fill_reg == DEPTH_C);
    assign nonempty = (fill_reg != '0);
    assign rdata    = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_QW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("queue fill above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("command popped from empty queue");

endmodule

`default_nettype wire

/* rtl/core/erle_back.sv */
// Back end: expands each command into coded bytes, one per cycle while the
// coded channel is ready, into an output register. Depends on erle_pkg, erle_out_if.
`default_nettype none

module erle_back #(
    parameter int LENGTH_WIDTH = erle_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [erle_pkg::BYTE_W-1:0] escape_byte,
    input  wire logic                        q_nonempty,
    input  wire erle_pkg::cmd_t              q_data,
    output logic                             q_pop,
    erle_out_if.source                       coded
);
    import erle_pkg::*;

    cmd_t                    cmd_reg;
    logic                    cmd_valid_reg, cmd_valid_next;
    logic [2:0]              pos_reg, pos_next;

    logic                    out_valid_reg;
    logic [BYTE_W-1:0]       out_byte_reg;
    logic                    out_bv_reg;
    logic                    out_end_reg;
    logic [LENGTH_WIDTH-1:0] out_total_reg;

    logic [2:0]              n_tot;
    logic                    last;
    logic                    in_a;
    logic [2:0]              rel;
    logic [1:0]              idx;
    run_t                    grp;
    logic [BYTE_W-1:0]       sel_byte;
    logic                    emit;
    logic                    load;
    logic                    bv;
    logic                    eob;
    logic [MAX_LENGTH_WIDTH-1:0] total_ext;

    always_comb
    begin
        n_tot = 3'(cmd_reg.a.nbytes) + 3'(cmd_reg.b.nbytes);
        // a command with no bytes is a bare end marker
        last  = (n_tot == '0) || (pos_reg == n_tot - 3'd1);
        in_a  = pos_reg < 3'(cmd_reg.a.nbytes);
        rel   = in_a ? pos_reg : pos_reg - 3'(cmd_reg.a.nbytes);
        idx   = rel[1:0];
        grp   = in_a ? cmd_reg.a : cmd_reg.b;
        if (grp.enc)
        begin
            case (idx)
                2'd0:    sel_byte = escape_byte;
                2'd1:    sel_byte = grp.val;
                default: sel_byte = grp.len;
            endcase
        end
        else
            sel_byte = grp.val;

        bv  = (n_tot != '0);
        eob = cmd_reg.fin && last;
        total_ext = MAX_LENGTH_WIDTH'(cmd_reg.total);

        emit = cmd_valid_reg && (!out_valid_reg || coded.ready);
        load = q_nonempty && (!cmd_valid_reg || (emit && last));
        q_pop = load;

        cmd_valid_next = cmd_valid_reg;
        pos_next       = pos_reg;
        if (load)
        begin
            cmd_valid_next = 1'b1;
            pos_next       = '0;
        end
        else if (emit)
        begin
            if (last)
                cmd_valid_next = 1'b0;
            else
                pos_next = pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= q_data;
        if (emit)
        begin
            out_byte_reg  <= bv ? sel_byte : '0;
            out_bv_reg    <= bv;
            out_end_reg   <= eob;
            out_total_reg <= eob ? total_ext[LENGTH_WIDTH-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            pos_reg       <= pos_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (coded.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign coded.valid         = out_valid_reg;
    assign coded.out_byte      = out_byte_reg;
    assign coded.byte_valid    = out_bv_reg;
    assign coded.end_of_buffer = out_end_reg;
    assign coded.total_length  = out_total_reg;

    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_bv_reg) |-> out_end_reg)
        else $error("bare marker without end of buffer");

    a_total_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_end_reg) |-> (out_total_reg == '0))
        else $error("total length set before end of buffer");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |-> (pos_reg < 3'd6))
        else $error("expansion position past six bytes");

endmodule

`default_nettype wire

/* rtl/core/escaped_run_length_encoder_core.sv */
// Escaped run-length encoder, top level.
// Channels: raw (sink) takes one byte per item with final_byte on the last
// byte of a buffer; coded (source) gives one coded byte per item, or a bare
// end marker (byte_valid 0) when a buffer's final byte produces nothing.
// The last item of a buffer carries end_of_buffer and total_length.
// Configuration: cfg_we/cfg_index/cfg_data write escape byte, run threshold,
// max run and output capacity; write them only while the block is idle.
// Throughput: one raw item per cycle while the queue is not full. Raw items
// that close no run and are not final produce no output. The back end
// emits one coded byte per cycle while coded is ready, and one item can
// expand to up to six coded bytes; the command queue (QUEUE_DEPTH entries)
// absorbs such bursts and raw.ready drops only while it is full. An item's
// first coded byte passes the queue, command and output registers.
// Reset: clears run state, queue and output register; config registers
// take their default values. A stalled coded channel holds its item and
// backs up into the queue, then into raw.ready.
`default_nettype none

module escaped_run_length_encoder_core #(
    parameter int LENGTH_WIDTH = erle_pkg::LENGTH_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = erle_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [erle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [erle_pkg::CFG_DATA_W-1:0] cfg_data,
    erle_in_if.sink                              raw,
    erle_out_if.source                           coded
);
    import erle_pkg::*;

    logic [BYTE_W-1:0] escape_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic [BYTE_W-1:0] max_run_reg;
    logic [CNT_W-1:0]  capacity_reg;

    logic acc;
    logic push;
    logic q_full;
    logic q_nonempty;
    logic q_pop;
    cmd_t cmd_w;
    cmd_t cmd_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg    <= ESCAPE_RST;
            threshold_reg <= THRESHOLD_RST;
            max_run_reg   <= MAX_RUN_RST;
            capacity_reg  <= CAPACITY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ESCAPE:    escape_reg    <= cfg_data[BYTE_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_MAX_RUN:   max_run_reg   <= cfg_data[BYTE_W-1:0];
                REG_CAPACITY:  capacity_reg  <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign raw.ready = !q_full;
    assign acc       = raw.valid && !q_full;

    erle_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .acc             (acc),
        .data_byte       (raw.data_byte),
        .final_byte      (raw.final_byte),
        .run_threshold   (threshold_reg),
        .max_run         (max_run_reg),
        .output_capacity (capacity_reg),
        .push            (push),
        .cmd             (cmd_w)
    );

    erle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (cmd_w),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .rdata    (cmd_r)
    );

    erle_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .escape_byte (escape_reg),
        .q_nonempty  (q_nonempty),
        .q_data      (cmd_r),
        .q_pop       (q_pop),
        .coded       (coded)
    );

endmodule

`default_nettype wire
